/* hdl/ovcr_pkg.sv */
// Shared types, constants and saturation functions of the circulation rate pipeline.
package ovcr_pkg;

	localparam int QW      = 32;
	localparam int NUM_W   = 34;
	localparam int DIV_LAT = QW + 1;

	typedef enum logic [2:0] {
		CFG_ART_VALVE_RES = 3'd0,
		CFG_ART_RES       = 3'd1,
		CFG_ART_COMP      = 3'd2,
		CFG_ART_UNSTR_VOL = 3'd3,
		CFG_PER_RES       = 3'd4,
		CFG_VEN_RES       = 3'd5,
		CFG_VEN_COMP      = 3'd6,
		CFG_VEN_UNSTR_VOL = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic        neg;
		logic        ovf;
		logic [QW-1:0] quo;
	} div_res_t;

	typedef struct packed {
		logic        sat;
		logic [31:0] val;
	} s32_res_t;

	typedef struct packed {
		logic        sat;
		logic [30:0] val;
	} u31_res_t;

	function automatic s32_res_t clamp_quo_s(div_res_t d);
		s32_res_t r;
		r.sat = 1'b0;
		r.val = d.quo;
		if (d.ovf) begin
			r.sat = 1'b1;
			r.val = d.neg ? 32'h8000_0000 : 32'h7fff_ffff;
		end else if (d.neg) begin
			if (d.quo > 32'h8000_0000) begin
				r.sat = 1'b1;
				r.val = 32'h8000_0000;
			end else begin
				r.val = ~d.quo + 32'd1;
			end
		end else if (d.quo[31]) begin
			r.sat = 1'b1;
			r.val = 32'h7fff_ffff;
		end
		return r;
	endfunction

	function automatic u31_res_t clamp_quo_u(div_res_t d);
		u31_res_t r;
		r.sat = 1'b0;
		r.val = d.quo[30:0];
		if (d.ovf || d.quo[31]) begin
			r.sat = 1'b1;
			r.val = 31'h7fff_ffff;
		end
		return r;
	endfunction

	function automatic s32_res_t clamp_s33(logic signed [32:0] x);
		s32_res_t r;
		r.sat = 1'b0;
		r.val = x[31:0];
		if (x[32] != x[31]) begin
			r.sat = 1'b1;
			r.val = x[32] ? 32'h8000_0000 : 32'h7fff_ffff;
		end
		return r;
	endfunction

endpackage

/* hdl/ovcr_div.sv */
// Pipelined restoring divider: (|num| << FRAC_BITS) / den, one quotient bit per stage.
module ovcr_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [ovcr_pkg::NUM_W-1:0] num,
	input  logic [ovcr_pkg::QW-1:0]           den,
	output ovcr_pkg::div_res_t                res
);
	import ovcr_pkg::*;

	localparam int NSH_W = NUM_W + FRAC_BITS;

	logic [NUM_W-1:0] mag;
	logic [NSH_W-1:0] nsh;
	logic [QW-1:0]    top;
	logic [QW-1:0]    den_eff;

	logic [QW-1:0] r_s   [0:QW-1];
	logic [QW-1:0] low_s [0:QW-1];
	logic [QW-1:0] q_s   [0:QW];
	logic          neg_s [0:QW];
	logic          ovf_s [0:QW];

	assign mag     = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign nsh     = {mag, FRAC_BITS'(0)};
	assign top     = QW'(nsh[NSH_W-1:QW]);
	assign den_eff = (den == '0) ? QW'(1) : den;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]   <= top;
			low_s[0] <= nsh[QW-1:0];
			q_s[0]   <= '0;
			neg_s[0] <= num[NUM_W-1];
			ovf_s[0] <= (mag != '0) && ((den == '0) || (top >= den));
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_bit
		logic [QW:0]   rx;
		logic [QW+1:0] rd;
		logic          borrow;

		assign rx     = {r_s[k], low_s[k][QW-1]};
		assign rd     = {1'b0, rx} - {2'b00, den_eff};
		assign borrow = rd[QW+1];

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k+1]   <= {q_s[k][QW-2:0], ~borrow};
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end

		if (k < QW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					r_s[k+1]   <= borrow ? rx[QW-1:0] : rd[QW-1:0];
					low_s[k+1] <= {low_s[k][QW-2:0], 1'b0};
				end
			end
		end
	end

	assign res = '{neg: neg_s[QW], ovf: ovf_s[QW], quo: q_s[QW]};

endmodule

/* hdl/ovcr_dly.sv */
// Enabled delay line that carries valid and side data alongside the dividers.
module ovcr_dly #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);
	logic [W-1:0] d_q [0:DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) d_q[i] <= '0;
		end else if (en) begin
			d_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) d_q[i] <= d_q[i-1];
		end
	end

	assign dout = d_q[DEPTH-1];

endmodule

/* hdl/one_ventricle_circulation_rates.sv */
// Top level: closed-loop one-ventricle circulation right-hand side pipeline.
//
// Takes one item per cycle unless held and returns one result item per input through
// one input stage, two 33-stage bit-per-cycle divider banks and five arithmetic
// stages. The two chained divisions set the latency; the whole pipeline holds
// when the result stage is full and m_tready is low. Values are signed fixed
// point with FRAC_BITS fraction bits; any clipped value sets the saturated bit.
// Write configuration only while no items are in flight.
module one_ventricle_circulation_rates #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// ventricle_pressure, art_volume, ven_volume
	input  logic [95:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// ventricle_volume_rate, arterial_volume_rate, venous_volume_rate,
	// arterial_pressure, venous_pressure, arterial_flow, peripheral_flow,
	// venous_flow, saturated, zero pad
	output logic [255:0] m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import ovcr_pkg::*;

	localparam logic [30:0] ONE = 31'(1) << FRAC_BITS;

	logic [30:0]        art_valve_res_q, art_res_q, art_comp_q, per_res_q;
	logic [30:0]        ven_res_q, ven_comp_q;
	logic signed [31:0] art_uv_q, ven_uv_q;
	logic [31:0]        rsum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			art_valve_res_q <= ONE;
			art_res_q       <= ONE;
			art_comp_q      <= ONE;
			art_uv_q        <= '0;
			per_res_q       <= ONE;
			ven_res_q       <= ONE;
			ven_comp_q      <= ONE;
			ven_uv_q        <= '0;
			rsum_q          <= '0;
		end else begin
			rsum_q <= 32'(art_valve_res_q) + 32'(art_res_q);
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_ART_VALVE_RES: art_valve_res_q <= cfg_data[30:0];
					CFG_ART_RES:       art_res_q       <= cfg_data[30:0];
					CFG_ART_COMP:      art_comp_q      <= cfg_data[30:0];
					CFG_ART_UNSTR_VOL: art_uv_q        <= cfg_data;
					CFG_PER_RES:       per_res_q       <= cfg_data[30:0];
					CFG_VEN_RES:       ven_res_q       <= cfg_data[30:0];
					CFG_VEN_COMP:      ven_comp_q      <= cfg_data[30:0];
					CFG_VEN_UNSTR_VOL: ven_uv_q        <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic va_out, vb_out;

	assign en       = !v_s6 || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= va_out;
			v_s3 <= v_s2;
			v_s4 <= vb_out;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// stage 1: volume differences
	logic signed [31:0]      in_pv, in_va, in_vv;
	logic signed [31:0]      pv_s1;
	logic signed [NUM_W-1:0] da_s1, dv_s1;

	assign in_pv = s_tdata[31:0];
	assign in_va = s_tdata[63:32];
	assign in_vv = s_tdata[95:64];

	always_ff @(posedge clk) begin
		if (en) begin
			pv_s1 <= in_pv;
			da_s1 <= NUM_W'(in_va) - NUM_W'(art_uv_q);
			dv_s1 <= NUM_W'(in_vv) - NUM_W'(ven_uv_q);
		end
	end

	// compliance pressures
	div_res_t           div_pa, div_pven;
	logic [31:0]        pv_a;

	ovcr_div #(.FRAC_BITS(FRAC_BITS)) u_div_pa (
		.clk(clk), .en(en), .num(da_s1), .den({1'b0, art_comp_q}), .res(div_pa)
	);
	ovcr_div #(.FRAC_BITS(FRAC_BITS)) u_div_pven (
		.clk(clk), .en(en), .num(dv_s1), .den({1'b0, ven_comp_q}), .res(div_pven)
	);
	ovcr_dly #(.W(33), .DEPTH(DIV_LAT)) u_dly_a (
		.clk(clk), .arst_n(arst_n), .en(en),
		.din({v_s1, pv_s1}), .dout({va_out, pv_a})
	);

	// stage 2: clip pressures
	s32_res_t           pac_c, pven_c;
	logic signed [31:0] pac_s2, pven_s2, pv_s2;
	logic               sat_s2;

	assign pac_c  = clamp_quo_s(div_pa);
	assign pven_c = clamp_quo_s(div_pven);

	always_ff @(posedge clk) begin
		if (en) begin
			pac_s2  <= pac_c.val;
			pven_s2 <= pven_c.val;
			pv_s2   <= pv_a;
			sat_s2  <= pac_c.sat | pven_c.sat;
		end
	end

	// stage 3: flow numerators, valves gate to zero
	logic signed [NUM_W-1:0] nart_s3, nper_s3, nven_s3;
	logic signed [31:0]      pac_s3, pven_s3;
	logic                    sat_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			nart_s3 <= (pv_s2 >= pac_s2) ? NUM_W'(pv_s2) - NUM_W'(pac_s2) : '0;
			nper_s3 <= NUM_W'(pac_s2) - NUM_W'(pven_s2);
			nven_s3 <= (pven_s2 >= pv_s2) ? NUM_W'(pven_s2) - NUM_W'(pv_s2) : '0;
			pac_s3  <= pac_s2;
			pven_s3 <= pven_s2;
			sat_s3  <= sat_s2;
		end
	end

	// flows
	div_res_t    div_fart, div_fper, div_fven;
	logic [31:0] pac_b, pven_b;
	logic        sat_b;

	ovcr_div #(.FRAC_BITS(FRAC_BITS)) u_div_fart (
		.clk(clk), .en(en), .num(nart_s3), .den(rsum_q), .res(div_fart)
	);
	ovcr_div #(.FRAC_BITS(FRAC_BITS)) u_div_fper (
		.clk(clk), .en(en), .num(nper_s3), .den({1'b0, per_res_q}), .res(div_fper)
	);
	ovcr_div #(.FRAC_BITS(FRAC_BITS)) u_div_fven (
		.clk(clk), .en(en), .num(nven_s3), .den({1'b0, ven_res_q}), .res(div_fven)
	);
	ovcr_dly #(.W(66), .DEPTH(DIV_LAT)) u_dly_b (
		.clk(clk), .arst_n(arst_n), .en(en),
		.din({v_s3, sat_s3, pac_s3, pven_s3}), .dout({vb_out, sat_b, pac_b, pven_b})
	);

	// stage 4: clip flows
	u31_res_t    fart_c, fven_c;
	s32_res_t    fper_c;
	logic [30:0] fart_s4, fven_s4;
	logic [31:0] fper_s4, pac_s4, pven_s4;
	logic        sat_s4;

	assign fart_c = clamp_quo_u(div_fart);
	assign fper_c = clamp_quo_s(div_fper);
	assign fven_c = clamp_quo_u(div_fven);

	always_ff @(posedge clk) begin
		if (en) begin
			fart_s4 <= fart_c.val;
			fper_s4 <= fper_c.val;
			fven_s4 <= fven_c.val;
			pac_s4  <= pac_b;
			pven_s4 <= pven_b;
			sat_s4  <= sat_b | fart_c.sat | fper_c.sat | fven_c.sat;
		end
	end

	// stage 5: pressure drop product and volume rates
	logic signed [32:0] xfart, xfven, xfper;
	s32_res_t           rvent_c, rart_c, rven_c;
	logic [61:0]        prod_s5;
	logic [30:0]        fart_s5, fven_s5;
	logic [31:0]        fper_s5, pac_s5, pven_s5;
	logic [31:0]        rvent_s5, rart_s5, rven_s5;
	logic               sat_s5;

	assign xfart   = signed'({2'b00, fart_s4});
	assign xfven   = signed'({2'b00, fven_s4});
	assign xfper   = signed'({fper_s4[31], fper_s4});
	assign rvent_c = clamp_s33(xfven - xfart);
	assign rart_c  = clamp_s33(xfart - xfper);
	assign rven_c  = clamp_s33(xfper - xfven);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s5  <= 62'(fart_s4) * 62'(art_res_q);
			fart_s5  <= fart_s4;
			fper_s5  <= fper_s4;
			fven_s5  <= fven_s4;
			pac_s5   <= pac_s4;
			pven_s5  <= pven_s4;
			rvent_s5 <= rvent_c.val;
			rart_s5  <= rart_c.val;
			rven_s5  <= rven_c.val;
			sat_s5   <= sat_s4 | rvent_c.sat | rart_c.sat | rven_c.sat;
		end
	end

	// stage 6: arterial pressure, result register
	logic [61:0]        ps;
	logic               ps_sat;
	logic [30:0]        psc;
	s32_res_t           part_c;
	logic [31:0]        rvent_s6, rart_s6, rven_s6, part_s6, pven_s6, fper_s6;
	logic [30:0]        fart_s6, fven_s6;
	logic               sat_s6;

	assign ps     = prod_s5 >> FRAC_BITS;
	assign ps_sat = |ps[61:31];
	assign psc    = ps_sat ? 31'h7fff_ffff : ps[30:0];
	assign part_c = clamp_s33(signed'({pac_s5[31], pac_s5}) + signed'({2'b00, psc}));

	always_ff @(posedge clk) begin
		if (en) begin
			rvent_s6 <= rvent_s5;
			rart_s6  <= rart_s5;
			rven_s6  <= rven_s5;
			part_s6  <= part_c.val;
			pven_s6  <= pven_s5;
			fart_s6  <= fart_s5;
			fper_s6  <= fper_s5;
			fven_s6  <= fven_s5;
			sat_s6   <= sat_s5 | ps_sat | part_c.sat;
		end
	end

	assign m_tdata = {1'b0, sat_s6, fven_s6, fper_s6, fart_s6, pven_s6, part_s6,
		rven_s6, rart_s6, rvent_s6};

endmodule

/* hdl/ovcr_chk.sv */
// Port checker for the circulation rate pipeline, bound to the top level.
module ovcr_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [255:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_vent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[254] |->
		m_tdata[31:0] == (32'(m_tdata[253:223]) - 32'(m_tdata[190:160])))
		else $error("ventricle rate does not match flows");

	a_loop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[254] |->
		(m_tdata[31:0] + m_tdata[63:32] + m_tdata[95:64]) == 32'd0)
		else $error("volume rates do not sum to zero");
endmodule

bind one_ventricle_circulation_rates ovcr_chk u_ovcr_chk (.*);

/* dv/tb_top.sv */
// Testbench for the circulation rate pipeline: table and random items against a predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ovcr_pkg::*;

	localparam int FB = 16;
	localparam longint S_MAX = 64'sd2147483647;
	localparam longint S_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [31:0] pv;
		logic [31:0] va;
		logic [31:0] vv;
	} rate_in_t;

	typedef struct {
		logic [31:0] r_ventr;
		logic [31:0] r_art;
		logic [31:0] r_ven;
		logic [31:0] p_art;
		logic [31:0] p_ven;
		logic [30:0] f_art;
		logic [31:0] f_per;
		logic [30:0] f_ven;
		logic        sat;
	} rates_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [95:0]  s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [255:0] m_tdata;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;

	one_ventricle_circulation_rates #(.FRAC_BITS(FB)) dut (.*);

	always #4 clk = ~clk;

	longint unsigned r_valve, r_art, c_art, r_per, r_ven, c_ven;
	longint v0_art, v0_ven;
	rates_t expected_rates[$];
	int errors = 0;

	function automatic longint clip(longint v, longint lo, longint hi, ref bit sat);
		if (v < lo) begin
			sat = 1;
			return lo;
		end
		if (v > hi) begin
			sat = 1;
			return hi;
		end
		return v;
	endfunction

	function automatic longint qdiv(longint num, longint unsigned den, longint lo,
			longint hi, ref bit sat);
		longint unsigned mag, q;
		bit neg;
		neg = num < 0;
		mag = neg ? -num : num;
		if (mag == 0)
			return 0;
		if (den == 0) begin
			sat = 1;
			return neg ? lo : hi;
		end
		q = (mag << FB) / den;
		if (neg) begin
			if (q > longint'(-lo)) begin
				sat = 1;
				return lo;
			end
			return -longint'(q);
		end
		if (q > hi) begin
			sat = 1;
			return hi;
		end
		return q;
	endfunction

	function automatic rates_t circ_rates(rate_in_t x);
		rates_t r;
		bit sat;
		longint pv, pac, pven, fart, fper, fven, part;
		longint unsigned prod;
		sat = 0;
		pv = longint'(signed'(x.pv));
		pac = qdiv(longint'(signed'(x.va)) - v0_art, c_art, S_MIN, S_MAX, sat);
		pven = qdiv(longint'(signed'(x.vv)) - v0_ven, c_ven, S_MIN, S_MAX, sat);
		fart = (pv >= pac) ? qdiv(pv - pac, r_valve + r_art, 0, S_MAX, sat) : 0;
		prod = (longint'(fart) * r_art) >> FB;
		if (prod > S_MAX) begin
			sat = 1;
			prod = S_MAX;
		end
		part = clip(pac + longint'(prod), S_MIN, S_MAX, sat);
		fper = qdiv(pac - pven, r_per, S_MIN, S_MAX, sat);
		fven = (pven >= pv) ? qdiv(pven - pv, r_ven, 0, S_MAX, sat) : 0;
		r.r_ventr = 32'(clip(fven - fart, S_MIN, S_MAX, sat));
		r.r_art = 32'(clip(fart - fper, S_MIN, S_MAX, sat));
		r.r_ven = 32'(clip(fper - fven, S_MIN, S_MAX, sat));
		r.p_art = 32'(part);
		r.p_ven = 32'(pven);
		r.f_art = 31'(fart);
		r.f_per = 32'(fper);
		r.f_ven = 31'(fven);
		r.sat = sat;
		return r;
	endfunction

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_ART_VALVE_RES: r_valve = 64'(val[30:0]);
			CFG_ART_RES:       r_art = 64'(val[30:0]);
			CFG_ART_COMP:      c_art = 64'(val[30:0]);
			CFG_ART_UNSTR_VOL: v0_art = longint'(signed'(val));
			CFG_PER_RES:       r_per = 64'(val[30:0]);
			CFG_VEN_RES:       r_ven = 64'(val[30:0]);
			CFG_VEN_COMP:      c_ven = 64'(val[30:0]);
			default:           v0_ven = longint'(signed'(val));
		endcase
	endtask

	task automatic drain;
		while (expected_rates.size() != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic send_item(rate_in_t x);
		repeat ($urandom_range(0, 13) * ($urandom_range(0, 3) != 0)) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {x.vv, x.va, x.pv};
		expected_rates.push_back(circ_rates(x));
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [31:0] rnd_val();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'h8000_0000 + $urandom_range(0, 3);
			2: return 32'h7fff_ffff - $urandom_range(0, 3);
			default: return signed'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
		endcase
	endfunction

	function automatic logic [31:0] rnd_coef();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(1, 8);
			default: return $urandom_range(32'h0000_4000, 32'h0004_0000);
		endcase
	endfunction

	// pv, va, vv; each row is sent after reset and again with extreme settings
	rate_in_t dir_in[12] = '{
		'{32'h0, 32'h0, 32'h0},
		'{32'h0001_0000, 32'h0, 32'h0},
		'{32'h0, 32'h0, 32'h0001_0000},
		'{32'h7fff_ffff, 32'h8000_0000, 32'h0},
		'{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff},
		'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff},
		'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
		'{32'hffff_ffff, 32'h0, 32'hffff_ffff},
		'{32'h0002_0000, 32'h0001_0000, 32'h0003_0000},
		'{32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678},
		'{32'haaaa_aaaa, 32'h5555_5555, 32'hedcb_a987},
		'{32'h0, 32'h8000_0000, 32'h7fff_ffff}
	};

	initial begin
		rate_in_t x;
		r_valve = 65536; r_art = 65536; c_art = 65536; r_per = 65536;
		r_ven = 65536; c_ven = 65536; v0_art = 0; v0_ven = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// typed-in checks at reset configuration
		begin
			rates_t z;
			z = circ_rates(dir_in[0]);
			if (z.sat !== 1'b0 || z.f_art !== '0 || z.r_art !== '0) begin
				$error("predictor zero row expected 0 actual %0d", z.r_art);
				errors++;
			end
			z = circ_rates(dir_in[1]);
			if (z.f_art !== 31'h8000 || z.p_art !== 32'h8000) begin
				$error("predictor arterial_flow expected 32768 actual %0d", z.f_art);
				errors++;
			end
		end
		foreach (dir_in[i])
			send_item(dir_in[i]);
		@(negedge clk);
		s_tvalid <= 1'b0;
		drain();
		// zero divisors and extreme settings
		write_reg(CFG_ART_COMP, 32'h0);
		write_reg(CFG_VEN_COMP, 32'h8000_0000);
		write_reg(CFG_PER_RES, 32'h0);
		write_reg(CFG_VEN_RES, 32'h0);
		write_reg(CFG_ART_VALVE_RES, 32'h0);
		write_reg(CFG_ART_RES, 32'h0);
		foreach (dir_in[i])
			send_item(dir_in[i]);
		@(negedge clk);
		s_tvalid <= 1'b0;
		drain();
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 7) begin
				write_reg(CFG_ART_VALVE_RES, 32'h7fff_ffff);
				write_reg(CFG_ART_RES, 32'hffff_ffff);
				write_reg(CFG_ART_COMP, 32'h7fff_ffff);
				write_reg(CFG_ART_UNSTR_VOL, 32'h8000_0000);
				write_reg(CFG_PER_RES, 32'h7fff_ffff);
				write_reg(CFG_VEN_RES, 32'h1);
				write_reg(CFG_VEN_COMP, 32'h1);
				write_reg(CFG_VEN_UNSTR_VOL, 32'h7fff_ffff);
			end else begin
				write_reg(CFG_ART_VALVE_RES, rnd_coef());
				write_reg(CFG_ART_RES, rnd_coef());
				write_reg(CFG_ART_COMP, rnd_coef());
				write_reg(CFG_ART_UNSTR_VOL, rnd_val());
				write_reg(CFG_PER_RES, rnd_coef());
				write_reg(CFG_VEN_RES, rnd_coef());
				write_reg(CFG_VEN_COMP, rnd_coef());
				write_reg(CFG_VEN_UNSTR_VOL, rnd_val());
			end
			for (int n = 0; n < 135; n++) begin
				x.pv = rnd_val();
				x.va = rnd_val();
				x.vv = rnd_val();
				send_item(x);
				if (ph == 3 && n == 60) begin
					@(negedge clk);
					s_tvalid <= 1'b0;
					while (expected_rates.size() != 0)
						@(negedge clk);
				end
			end
			@(negedge clk);
			s_tvalid <= 1'b0;
			drain();
		end
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	int stall = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall > 0) begin
			stall <= stall - 1;
			m_tready <= 1'b0;
		end else if (m_tready && m_tvalid) begin
			if ($urandom_range(0, 3) == 0) begin
				stall <= $urandom_range(0, 13);
				m_tready <= 1'b0;
			end
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		rates_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_rates.size() == 0) begin
				$error("unexpected item: %h", m_tdata);
				errors++;
			end else begin
				e = expected_rates.pop_front();
				if (m_tdata[31:0] !== e.r_ventr) begin
					$error("ventricle_volume_rate expected %h actual %h", e.r_ventr, m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[63:32] !== e.r_art) begin
					$error("arterial_volume_rate expected %h actual %h", e.r_art, m_tdata[63:32]);
					errors++;
				end
				if (m_tdata[95:64] !== e.r_ven) begin
					$error("venous_volume_rate expected %h actual %h", e.r_ven, m_tdata[95:64]);
					errors++;
				end
				if (m_tdata[127:96] !== e.p_art) begin
					$error("arterial_pressure expected %h actual %h", e.p_art, m_tdata[127:96]);
					errors++;
				end
				if (m_tdata[159:128] !== e.p_ven) begin
					$error("venous_pressure expected %h actual %h", e.p_ven, m_tdata[159:128]);
					errors++;
				end
				if (m_tdata[190:160] !== e.f_art) begin
					$error("arterial_flow expected %h actual %h", e.f_art, m_tdata[190:160]);
					errors++;
				end
				if (m_tdata[222:191] !== e.f_per) begin
					$error("peripheral_flow expected %h actual %h", e.f_per, m_tdata[222:191]);
					errors++;
				end
				if (m_tdata[253:223] !== e.f_ven) begin
					$error("venous_flow expected %h actual %h", e.f_ven, m_tdata[253:223]);
					errors++;
				end
				if (m_tdata[254] !== e.sat) begin
					$error("saturated expected %b actual %b", e.sat, m_tdata[254]);
					errors++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end
endmodule
